/* src/nearest_point_value_lookup_top_defines.svh */
// Assertion macros used by the nearest point value lookup back end.
`ifndef NEAREST_POINT_VALUE_LOOKUP_TOP_DEFINES_SVH
`define NEAREST_POINT_VALUE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define NPVL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("npvl: same-cycle check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define NPVL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("npvl: next-cycle check failed");

`endif

/* src/npvl_pkg.sv */
// Shared types and constants for the nearest point value lookup block.
package npvl_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIST_W      = 64;
    localparam int OUT_DIST_W  = 50;
    localparam int OUT_INDEX_W = 10;
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;

    typedef enum logic [1:0] {
        KIND_COORD = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_QUERY = 2'd2
    } npvl_kind_t;

    typedef enum logic [OP_W-1:0] {
        OP_COORD = 2'd0,
        OP_VALUE = 2'd1,
        OP_QUERY = 2'd2
    } npvl_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOC_COUNT  = 3'd0,
        CFG_SPACE_DIMS = 3'd1,
        CFG_SEL_COUNT  = 3'd2,
        CFG_SELECT_0   = 3'd3,
        CFG_SELECT_1   = 3'd4,
        CFG_SELECT_2   = 3'd5,
        CFG_SELECT_3   = 3'd6
    } npvl_cfg_idx_t;

    // Settings the back end reads during a query; already clamped and wrapped.
    typedef struct packed {
        logic [1:0]      space_dims;
        logic [2:0]      sel_count;
        logic [3:0][2:0] select;
    } npvl_cfg_t;

endpackage

/* src/npvl_front.sv */
// Front end: accepts requests, drops unusable ones and forms queue commands.
module npvl_front
    import npvl_pkg::*;
#(
    parameter int MAX_LOCATIONS       = 1024,
    parameter int VALUES_PER_LOCATION = 8,
    parameter int COORD_BITS          = 24,
    parameter int ADDR_W              = 10,
    parameter int VA_W                = 13,
    parameter int PAY_W               = 137
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [9:0]                   s_loc_index,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    input  logic [2:0]                   s_value_slot,
    input  logic [31:0]                  s_value_word,
    input  logic [1:0]                   space_dims,
    output logic                         f_valid,
    input  logic                         f_ready,
    output npvl_op_t                     f_op,
    output logic [PAY_W-1:0]             f_data
);

    logic              vld_reg, vld_next;
    npvl_op_t          op_reg, op_next;
    logic [PAY_W-1:0]  data_reg, data_next;
    logic              keep;
    logic              in_range;
    logic              slot_ok;
    logic              is_query;
    logic [31:0]       va32;
    logic [COORD_BITS-1:0] cx, cy, cz;

    // Stage is free when empty or when its command leaves this cycle.
    assign s_ready = !vld_reg || f_ready;

    always_comb begin
        in_range = 32'(s_loc_index) < 32'(MAX_LOCATIONS);
        slot_ok  = 32'(s_value_slot) < 32'(VALUES_PER_LOCATION);
        is_query = s_kind == KIND_QUERY;
        va32     = 32'(s_loc_index) * 32'(VALUES_PER_LOCATION) + 32'(s_value_slot);
        // Unused query coordinates read as zero.
        cx = (is_query && space_dims < 2'd1) ? '0 : s_coord_x;
        cy = (is_query && space_dims < 2'd2) ? '0 : s_coord_y;
        cz = (is_query && space_dims < 2'd3) ? '0 : s_coord_z;
        keep    = 1'b0;
        op_next = OP_QUERY;
        case (s_kind)
            KIND_COORD: begin
                keep    = in_range;
                op_next = OP_COORD;
            end
            KIND_VALUE: begin
                keep    = in_range && slot_ok;
                op_next = OP_VALUE;
            end
            KIND_QUERY: begin
                keep    = 1'b1;
                op_next = OP_QUERY;
            end
            default: begin
                keep    = 1'b0;
                op_next = OP_QUERY;
            end
        endcase
        data_next = {ADDR_W'(s_loc_index), VA_W'(va32), cx, cy, cz, s_value_word};
        vld_next  = vld_reg;
        if (s_ready) begin
            vld_next = s_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg   <= op_next;
            data_reg <= data_next;
        end
    end

    assign f_valid = vld_reg;
    assign f_op    = op_reg;
    assign f_data  = data_reg;

endmodule

/* src/npvl_fifo.sv */
// Two-entry command queue between the front end and the back end.
module npvl_fifo #(
    parameter int WIDTH = 139
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = cnt_reg != CNT_W'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* src/npvl_back.sv */
// Back end: location stores, nearest-location scan pipeline and result output.
`include "nearest_point_value_lookup_top_defines.svh"

module npvl_back
    import npvl_pkg::*;
#(
    parameter int MAX_LOCATIONS       = 1024,
    parameter int VALUES_PER_LOCATION = 8,
    parameter int COORD_BITS          = 24,
    parameter int ADDR_W              = 10,
    parameter int CNT_W               = 11,
    parameter int VA_W                = 13,
    parameter int PAY_W               = 137
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  npvl_op_t                q_op,
    input  logic [PAY_W-1:0]        q_data,
    input  logic [CNT_W-1:0]        loc_count,
    input  npvl_cfg_t               cfg,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_INDEX_W-1:0]  m_nearest_index,
    output logic [OUT_DIST_W-1:0]   m_distance_squared,
    output logic [1:0]              m_result_position,
    output logic [VALUE_W-1:0]      m_result_value,
    output logic                    m_last
);

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;
    localparam int VDEP  = MAX_LOCATIONS * VALUES_PER_LOCATION;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_DRAIN   = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_LD = 5'b10000
    } npvl_state_t;

    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] idx;
    } npvl_tag_t;

    npvl_state_t state_reg, state_next;

    logic [CB-1:0]      x_mem [MAX_LOCATIONS];
    logic [CB-1:0]      y_mem [MAX_LOCATIONS];
    logic [CB-1:0]      z_mem [MAX_LOCATIONS];
    logic [VALUE_W-1:0] value_mem [VDEP];

    logic [ADDR_W-1:0]  p_addr;
    logic [VA_W-1:0]    p_vaddr;
    logic [2:0][CB-1:0] p_coord;
    logic [VALUE_W-1:0] p_word;
    logic               pop;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  scan_addr;
    logic               scan_last;
    logic               crd_en;
    logic [2:0][CB-1:0] q_reg;
    logic [2:0][CB-1:0] rd_reg;

    npvl_tag_t          tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;
    logic [2:0][CB-1:0]   ab_next, ab_reg;
    logic [2:0][SQ_W-1:0] sq_reg;
    logic [SUM_W-1:0]     sum;
    logic [DIST_W-1:0]    dist_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic [ADDR_W-1:0]    best_idx_reg;
    logic                 take;

    logic [1:0]         pos_reg, pos_next;
    logic               emit_last;
    logic               vrd_en;
    logic [31:0]        va32;
    logic [VA_W-1:0]    emit_vaddr;
    logic [VALUE_W-1:0] vr_reg;
    logic               out_free;
    logic               out_load;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_INDEX_W-1:0] m_index_reg;
    logic [OUT_DIST_W-1:0]  m_dist_reg;
    logic [1:0]             m_pos_reg;
    logic [VALUE_W-1:0]     m_value_reg;
    logic                   m_last_reg;

    // Unpack the queue command.
    assign p_addr     = q_data[PAY_W-1 -: ADDR_W];
    assign p_vaddr    = q_data[PAY_W-ADDR_W-1 -: VA_W];
    assign p_coord[0] = q_data[3*CB+VALUE_W-1 -: CB];
    assign p_coord[1] = q_data[2*CB+VALUE_W-1 -: CB];
    assign p_coord[2] = q_data[CB+VALUE_W-1 -: CB];
    assign p_word     = q_data[VALUE_W-1:0];

    assign q_ready = state_reg == ST_IDLE;
    assign pop     = q_valid && q_ready;

    assign crd_en    = state_reg == ST_SCAN;
    assign scan_addr = idx_reg[ADDR_W-1:0];
    assign scan_last = idx_reg == loc_count - CNT_W'(1);

    assign va32       = 32'(best_idx_reg) * 32'(VALUES_PER_LOCATION)
                      + 32'(cfg.select[pos_reg]);
    assign emit_vaddr = VA_W'(va32);
    assign vrd_en     = state_reg == ST_EMIT_RD;
    assign emit_last  = (3'(pos_reg) + 3'd1) == cfg.sel_count;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = (state_reg == ST_EMIT_LD) && out_free;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && q_op == OP_QUERY) begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Wait for the last location to reach the compare stage.
                if (tag_d_reg.vld && tag_d_reg.last) begin
                    state_next = ST_EMIT_RD;
                    pos_next   = '0;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT_RD;
                        pos_next   = pos_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            tag_a_reg   <= '0;
            tag_b_reg   <= '0;
            tag_c_reg   <= '0;
            tag_d_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            tag_a_reg   <= '{vld: crd_en, first: idx_reg == '0, last: scan_last,
                             idx: scan_addr};
            tag_b_reg   <= tag_a_reg;
            tag_c_reg   <= tag_b_reg;
            tag_d_reg   <= tag_c_reg;
        end
    end

    // Coordinate stores: one write port, one registered read port each.
    always_ff @(posedge aclk) begin
        if (pop && q_op == OP_COORD) begin
            x_mem[p_addr] <= p_coord[0];
            y_mem[p_addr] <= p_coord[1];
            z_mem[p_addr] <= p_coord[2];
        end
        if (crd_en) begin
            rd_reg[0] <= x_mem[scan_addr];
            rd_reg[1] <= y_mem[scan_addr];
            rd_reg[2] <= z_mem[scan_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_op == OP_VALUE) begin
            value_mem[p_vaddr] <= p_word;
        end
        if (vrd_en) begin
            vr_reg <= value_mem[emit_vaddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_op == OP_QUERY) begin
            q_reg <= p_coord;
        end
    end

    // Absolute coordinate differences; unused stored coordinates read as zero.
    always_comb begin
        logic signed [CB:0] pe;
        logic signed [CB:0] qe;
        logic signed [CB:0] d;
        for (int k = 0; k < 3; k++) begin
            pe = (cfg.space_dims > 2'(k)) ? {rd_reg[k][CB-1], rd_reg[k]} : '0;
            qe = {q_reg[k][CB-1], q_reg[k]};
            d  = pe - qe;
            ab_next[k] = d[CB] ? CB'(-d) : CB'(d);
        end
    end

    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign take = tag_d_reg.vld && (tag_d_reg.first || dist_reg < best_dist_reg);

    always_ff @(posedge aclk) begin
        ab_reg <= ab_next;
        for (int k = 0; k < 3; k++) begin
            sq_reg[k] <= SQ_W'(ab_reg[k]) * SQ_W'(ab_reg[k]);
        end
        dist_reg <= DIST_W'(sum);
        // Strict compare: on a tie the lower index stays.
        if (take) begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= tag_d_reg.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= OUT_INDEX_W'(best_idx_reg);
            m_dist_reg  <= best_dist_reg[OUT_DIST_W-1:0];
            m_pos_reg   <= pos_reg;
            m_value_reg <= vr_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_nearest_index    = m_index_reg;
    assign m_distance_squared = m_dist_reg;
    assign m_result_position  = m_pos_reg;
    assign m_result_value     = m_value_reg;
    assign m_last             = m_last_reg;

    `NPVL_ASSERT_IMPL(a_drained_before_emit, state_reg == ST_EMIT_RD, !tag_a_reg.vld && !tag_b_reg.vld && !tag_c_reg.vld && !tag_d_reg.vld)
    `NPVL_ASSERT_IMPL(a_result_from_emit, $rose(m_valid_reg), $past(state_reg == ST_EMIT_LD))
    `NPVL_ASSERT_IMPL(a_tag_from_scan, tag_a_reg.vld, $past(state_reg == ST_SCAN))
    `NPVL_ASSERT_NEXT(a_first_sets_best, tag_d_reg.vld && tag_d_reg.first, best_idx_reg == '0)

endmodule

/* src/nearest_point_value_lookup_top.sv */
// Query flow: an accepted query scans every stored location, drains the pipeline, then
// reads and registers one result per selected value. The back end holds one query at a time,
// takes no new command until it is done, and reads one stored location per cycle from the coordinate stores.
// Load requests occupy the back end for one cycle each.
// Reset: synchronous, active low; clears control and sets registers to their reset
// values. Stores are not cleared and read as undefined until written.
module nearest_point_value_lookup_top
    import npvl_pkg::*;
#(
    parameter int MAX_LOCATIONS       = 1024,
    parameter int VALUES_PER_LOCATION = 8,
    parameter int MAX_SELECTED        = 4,
    parameter int COORD_BITS          = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [9:0]                   s_loc_index,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    input  logic [2:0]                   s_value_slot,
    input  logic [31:0]                  s_value_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [9:0]                   m_nearest_index,
    output logic [49:0]                  m_distance_squared,
    output logic [1:0]                   m_result_position,
    output logic [31:0]                  m_result_value,
    output logic                         m_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(MAX_LOCATIONS);
    localparam int CNT_W  = $clog2(MAX_LOCATIONS + 1);
    localparam int VA_W   = $clog2(MAX_LOCATIONS * VALUES_PER_LOCATION);
    localparam int PAY_W  = ADDR_W + VA_W + 3 * COORD_BITS + VALUE_W;
    localparam int Q_W    = PAY_W + OP_W;

    logic [CNT_W-1:0] loc_count_reg, loc_count_next;
    npvl_cfg_t        cfg_reg, cfg_next;
    logic [31:0]      cnt_req;
    logic [31:0]      sel_req;
    logic             cfg_wr;

    logic             f_valid, f_ready;
    npvl_op_t         f_op;
    logic [PAY_W-1:0] f_data;
    logic             q_valid, q_ready;
    logic [Q_W-1:0]   q_word;

    // Fold a select value into the range of value words.
    function automatic logic [2:0] wrap_slot(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (32'(r) >= 32'(VALUES_PER_LOCATION)) begin
                r = r - 3'(VALUES_PER_LOCATION);
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cnt_req   = 32'(cfg_data[10:0]);
    assign sel_req   = 32'(cfg_data[2:0]);

    always_comb begin
        loc_count_next = loc_count_reg;
        cfg_next       = cfg_reg;
        if (cfg_wr) begin
            case (cfg_index)
                CFG_LOC_COUNT: begin
                    if (cnt_req == '0) begin
                        loc_count_next = CNT_W'(1);
                    end else if (cnt_req > 32'(MAX_LOCATIONS)) begin
                        loc_count_next = CNT_W'(MAX_LOCATIONS);
                    end else begin
                        loc_count_next = CNT_W'(cnt_req);
                    end
                end
                CFG_SPACE_DIMS: cfg_next.space_dims = cfg_data[1:0];
                CFG_SEL_COUNT: begin
                    if (sel_req == '0) begin
                        cfg_next.sel_count = 3'd1;
                    end else if (sel_req > 32'(MAX_SELECTED)) begin
                        cfg_next.sel_count = 3'(MAX_SELECTED);
                    end else begin
                        cfg_next.sel_count = cfg_data[2:0];
                    end
                end
                CFG_SELECT_0: cfg_next.select[0] = wrap_slot(cfg_data[2:0]);
                CFG_SELECT_1: cfg_next.select[1] = wrap_slot(cfg_data[2:0]);
                CFG_SELECT_2: cfg_next.select[2] = wrap_slot(cfg_data[2:0]);
                CFG_SELECT_3: cfg_next.select[3] = wrap_slot(cfg_data[2:0]);
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loc_count_reg      <= CNT_W'(1);
            cfg_reg.space_dims <= 2'd3;
            cfg_reg.sel_count  <= 3'd1;
            cfg_reg.select     <= '0;
        end else begin
            loc_count_reg <= loc_count_next;
            cfg_reg       <= cfg_next;
        end
    end

    npvl_front #(
        .MAX_LOCATIONS      (MAX_LOCATIONS),
        .VALUES_PER_LOCATION(VALUES_PER_LOCATION),
        .COORD_BITS         (COORD_BITS),
        .ADDR_W             (ADDR_W),
        .VA_W               (VA_W),
        .PAY_W              (PAY_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_loc_index (s_loc_index),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_coord_z   (s_coord_z),
        .s_value_slot(s_value_slot),
        .s_value_word(s_value_word),
        .space_dims  (cfg_reg.space_dims),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_op        (f_op),
        .f_data      (f_data)
    );

    npvl_fifo #(
        .WIDTH(Q_W)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  ({f_op, f_data}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_word)
    );

    npvl_back #(
        .MAX_LOCATIONS      (MAX_LOCATIONS),
        .VALUES_PER_LOCATION(VALUES_PER_LOCATION),
        .COORD_BITS         (COORD_BITS),
        .ADDR_W             (ADDR_W),
        .CNT_W              (CNT_W),
        .VA_W               (VA_W),
        .PAY_W              (PAY_W)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_op              (npvl_op_t'(q_word[Q_W-1 -: OP_W])),
        .q_data            (q_word[PAY_W-1:0]),
        .loc_count         (loc_count_reg),
        .cfg               (cfg_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_nearest_index   (m_nearest_index),
        .m_distance_squared(m_distance_squared),
        .m_result_position (m_result_position),
        .m_result_value    (m_result_value),
        .m_last            (m_last)
    );

endmodule
